// ===== rtl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [6:0]         position;
    logic signed [31:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [6:0]         item_count;
    logic               is_empty;
  } ple_out_t;

  // Per-command control broadcast to every cell.
  typedef struct packed {
    logic wr;
    logic ins;
    logic rem;
  } ple_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// One list slot: holds an element and shifts it to or from its neighbors.
`default_nettype none

module ple_cell #(
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire ple_pkg::ple_ctl_t     ctl,
  input  wire logic [CNT_W-1:0]      pos,
  input  wire logic [VALUE_BITS-1:0] wdata,
  input  wire logic [VALUE_BITS-1:0] left_val,
  input  wire logic [VALUE_BITS-1:0] right_val,
  output logic      [VALUE_BITS-1:0] val,
  output logic      [VALUE_BITS-1:0] taken
);

  import ple_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.rem && (MY_IDX >= pos)) begin
      // close the gap: pull from the right neighbor
      val_nxt = right_val;
    end else if (ctl.wr && (MY_IDX == pos)) begin
      val_nxt = wdata;
    end else if (ctl.ins && (MY_IDX > pos)) begin
      // open a gap: take the left neighbor's element
      val_nxt = left_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign taken = (ctl.rem && (MY_IDX == pos)) ? val_r : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: command decode and a row of slot cells.
//
// Bounded ordered list of signed values held in a row of CAPACITY cells.
// Input: a command (op, position, value) is taken at a rising edge with
// start high and busy low. Ops: append, insert at position, update at
// position, remove at position, clear; other codes do nothing.
// Output: exactly one result per command, shown on out_data for one cycle
// with out_valid high, on the cycle after the command is taken. The result
// carries a status (ok, invalid position, full), the removed value, the
// element count after the command and an empty flag.
// Throughput: one command per cycle. Every cell moves in the same cycle, so
// an insert or remove shifts the whole tail at once; busy is high in reset
// and for the cycle right after it, and low otherwise.
// Reset (rst_n low, synchronous): the list becomes empty, no result is
// pending. Element contents are not cleared; only slots below the count
// are ever read.
// The receiver cannot stall: each result is a single-cycle transfer.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ple_pkg::ple_in_t  in_data,
  output logic                   out_valid,
  output ple_pkg::ple_out_t      out_data
);

  import ple_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int WIDE_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  logic                  busy_r;
  logic [CNT_W-1:0]      length_r;
  logic [CNT_W-1:0]      length_nxt;
  logic                  out_valid_r;
  ple_out_t              out_r;
  ple_out_t              out_nxt;

  logic                  accept;
  ple_ctl_t              ctl;
  logic [1:0]            status;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      len_ext;
  logic [CNT_W-1:0]      cell_pos;
  logic                  full;
  logic [WIDE_W-1:0]     value_ext;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] removed;
  logic [WIDE_W-1:0]     removed_ext;
  logic [CMP_W-1:0]      len_nxt_ext;

  logic [VALUE_BITS-1:0] cell_val   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_taken [CAPACITY];
  logic [VALUE_BITS-1:0] left_w     [CAPACITY];
  logic [VALUE_BITS-1:0] right_w    [CAPACITY];

  assign accept    = start && !busy_r;
  assign pos_ext   = CMP_W'(in_data.position);
  assign len_ext   = CMP_W'(length_r);
  assign full      = (length_r == CNT_W'(CAPACITY));
  assign value_ext = WIDE_W'(in_data.value);
  assign wdata     = value_ext[VALUE_BITS-1:0];

  // Command decode
  always_comb begin
    ctl        = '0;
    status     = ST_OK;
    length_nxt = length_r;
    cell_pos   = pos_ext[CNT_W-1:0];
    unique case (in_data.op)
      OP_APPEND: begin
        cell_pos = length_r;
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.wr     = accept;
          length_nxt = length_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (pos_ext > len_ext) begin
          status = ST_BAD_POS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctl.wr     = accept;
          ctl.ins    = accept;
          length_nxt = length_r + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (pos_ext >= len_ext) begin
          status = ST_BAD_POS;
        end else begin
          ctl.wr = accept;
        end
      end
      OP_REMOVE: begin
        if (pos_ext >= len_ext) begin
          status = ST_BAD_POS;
        end else begin
          ctl.rem    = accept;
          length_nxt = length_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        length_nxt = '0;
      end
      default: begin
        length_nxt = length_r;
      end
    endcase
  end

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_mid_r
      assign right_w[i] = cell_val[i+1];
    end

    ple_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cell_pos),
      .wdata     (wdata),
      .left_val  (left_w[i]),
      .right_val (right_w[i]),
      .val       (cell_val[i]),
      .taken     (cell_taken[i])
    );
  end

  // Only the addressed cell drives a nonzero value on remove
  always_comb begin
    removed = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      removed = removed | cell_taken[k];
    end
  end

  assign removed_ext = WIDE_W'(signed'(removed));
  assign len_nxt_ext = CMP_W'(length_nxt);

  always_comb begin
    out_nxt               = '0;
    out_nxt.status        = status;
    out_nxt.removed_value = removed_ext[31:0];
    out_nxt.item_count    = len_nxt_ext[6:0];
    out_nxt.is_empty      = (length_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        length_r <= length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted command produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid_r)
    else $error("result without a command");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_remove_len: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctl.rem) |=> (length_r == $past(length_r) - CNT_W'(1)))
    else $error("remove did not drop the count by one");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> (out_r.removed_value == '0))
    else $error("rejected command returned a value");

endmodule

`default_nettype wire
